>>> hdl/assert_macros.svh
// Assertion macros used by sacl_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define SACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sacl assertion failed");

// Implication checked in the next cycle.
`define SACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sacl assertion failed");

`endif

>>> hdl/sacl_pkg.sv
// Shared types and constants of the set-associative LFU cache tag model.
// No dependencies.
package sacl_pkg;

  // default sizes
  localparam int unsigned DEF_MAX_SETS    = 64;
  localparam int unsigned DEF_MAX_WAYS    = 4;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAY_BITS    = 2'd2;

  localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
  localparam logic [2:0] RST_INDEX_BITS  = 3'd6;
  localparam logic [1:0] RST_WAY_BITS    = 2'd2;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] address;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic       write_back;
    logic [1:0] way_used;
    logic       was_write;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic lookup;  // start RAM read of the addressed set
    logic commit;  // write updated set back, load result
    logic clear;   // write one zero row of the clearing sweep
  } sacl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } sacl_stat_t;

endpackage

>>> hdl/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sacl_ctrl.sv
// Sequencer of the LFU cache: clearing sweep, lookup, update and result handoff.
// Depends on sacl_pkg.
module sacl_ctrl import sacl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output sacl_cmd_t  cmd_o,
  input  sacl_stat_t stat_i
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CMP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.lookup = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == S_CMP) && (!out_valid_q || !out_stall_i);
    cmd_o.clear  = (state_q == S_CLEAR);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_o.lookup) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (cmd_o.commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/sacl_dp.sv
// Datapath of the LFU cache: config registers, set/tag split, way compare,
// LFU victim pick, line update and result register. Depends on sacl_pkg.
module sacl_dp import sacl_pkg::*; #(
  parameter int unsigned MAX_SETS    = DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS    = DEF_MAX_WAYS,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
  localparam int unsigned SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int unsigned ROW_W      = MAX_WAYS * (34 + COUNT_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_word_t              in_word_i,
  input  sacl_cmd_t             cmd_i,
  output sacl_stat_t            stat_o,
  output logic                  ram_we_o,
  output logic [SET_W-1:0]      ram_waddr_o,
  output logic [ROW_W-1:0]      ram_wdata_o,
  output logic                  ram_re_o,
  output logic [SET_W-1:0]      ram_raddr_o,
  input  logic [ROW_W-1:0]      ram_rdata_i,
  output out_word_t             out_word_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned LINE_W = 34 + CW;
  localparam int unsigned VLD_B  = LINE_W - 1;
  localparam int unsigned DRT_B  = LINE_W - 2;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned IB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned WB_MAX = $clog2(MAX_WAYS + 1) - 1;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // config
  logic [3:0] off_q;
  logic [2:0] ib_q;
  logic [1:0] wb_q;
  logic [3:0] ib_eff;
  logic [2:0] wb_eff;

  // lookup registers
  opcode_e          op_q;
  logic [31:0]      tag_q;
  logic [SET_W-1:0] set_q;
  logic [SET_W-1:0] clr_cnt_q;
  out_word_t        out_q;

  logic [31:0] set_full;
  logic [31:0] tag_in;
  logic [4:0]  shift;

  logic [MAX_WAYS-1:0][LINE_W-1:0] rd_row, row_d;
  logic [MAX_WAYS-1:0]             way_use;
  logic                            hit;
  logic [WAY_W-1:0]                hit_way, vic_way, sel;
  logic [CW-1:0]                   best;
  logic [LINE_W-1:0]               old_line, new_line;
  logic                            wback;
  logic [WAY_W+1:0]                sel_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= RST_OFFSET_BITS;
      ib_q  <= RST_INDEX_BITS;
      wb_q  <= RST_WAY_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_BITS: off_q <= cfg_data_i;
        CFG_INDEX_BITS:  ib_q  <= cfg_data_i[2:0];
        CFG_WAY_BITS:    wb_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // clamp to what the array holds
  assign ib_eff = ({1'b0, ib_q} > 4'(IB_MAX)) ? 4'(IB_MAX) : {1'b0, ib_q};
  assign wb_eff = ({1'b0, wb_q} > 3'(WB_MAX)) ? 3'(WB_MAX) : {1'b0, wb_q};

  // set and tag split of the incoming address
  assign shift    = 5'(off_q) + 5'(ib_eff);
  assign set_full = (in_word_i.address >> off_q) & ((32'd1 << ib_eff) - 32'd1);
  assign tag_in   = in_word_i.address >> shift;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      op_q  <= in_word_i.opcode;
      tag_q <= tag_in;
      set_q <= set_full[SET_W-1:0];
    end
  end

  // sweep pointer for the post-reset clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear && !stat_o.clear_last) begin
      clr_cnt_q <= clr_cnt_q + SET_W'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == SET_W'(MAX_SETS - 1));

  assign rd_row = ram_rdata_i;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_use[w] = ((32'(w) >> wb_eff) == 32'd0);
    end
  end

  // lowest matching way
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_use[w] && !hit && rd_row[w][VLD_B] && (rd_row[w][CW +: 32] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // smallest use count, lowest way on ties
  always_comb begin
    best    = rd_row[0][CW-1:0];
    vic_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (way_use[w] && (rd_row[w][CW-1:0] < best)) begin
        best    = rd_row[w][CW-1:0];
        vic_way = WAY_W'(w);
      end
    end
  end

  assign sel      = hit ? hit_way : vic_way;
  assign old_line = rd_row[sel];
  assign wback    = !hit && old_line[VLD_B] && old_line[DRT_B];

  always_comb begin
    new_line = old_line;
    if (hit) begin
      if (old_line[CW-1:0] != CNT_MAX) begin
        new_line[CW-1:0] = old_line[CW-1:0] + CW'(1);
      end
      if (op_q == OP_WRITE) begin
        new_line[DRT_B] = 1'b1;
      end
    end else begin
      new_line[VLD_B]     = 1'b1;
      new_line[DRT_B]     = (op_q == OP_WRITE);
      new_line[CW +: 32]  = tag_q;
      new_line[CW-1:0]    = CW'(1);
    end
    row_d      = rd_row;
    row_d[sel] = new_line;
  end

  assign sel_ext = {2'b00, sel};

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.hit        <= hit;
      out_q.write_back <= wback;
      out_q.way_used   <= sel_ext[1:0];
      out_q.was_write  <= (op_q == OP_WRITE);
    end
  end

  assign ram_re_o    = cmd_i.lookup;
  assign ram_raddr_o = set_full[SET_W-1:0];
  assign ram_we_o    = cmd_i.commit || cmd_i.clear;
  assign ram_waddr_o = cmd_i.clear ? clr_cnt_q : set_q;
  assign ram_wdata_o = cmd_i.clear ? '0 : row_d;
  assign out_word_o  = out_q;

endmodule

>>> hdl/set_assoc_cache_lfu.sv
// Top level of the set-associative write-back LFU cache tag model.
// Depends on sacl_pkg, sacl_ctrl, sacl_dp, sacl_ram.
//
//   port group     dir   handshake                  word
//   in_*           in    in_valid_i / in_stall_o    in_word_t  {opcode, address}
//   out_*          out   out_valid_o / out_stall_i  out_word_t {hit, write_back, way_used, was_write}
//   cfg_*          in    cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// An access does the registered read of its set row, then compares,
// picks the LFU victim and writes the row back.
// After reset a clearing sweep zeroes the tag RAM, one set per cycle, so
// no word is taken until the sweep ends; config writes still land.
// The result sits in an output register; a stalled result holds the next
// access in its compare step until the register frees up.
module set_assoc_cache_lfu import sacl_pkg::*; #(
  parameter int unsigned MAX_SETS    = DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS    = DEF_MAX_WAYS,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  // one RAM row per set: all ways of {valid, dirty, tag, use count}
  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned ROW_W = MAX_WAYS * (34 + COUNT_WIDTH);

  sacl_cmd_t        cmd;
  sacl_stat_t       stat;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  // sequencing and output-valid handling
  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // address split, hit/victim logic, line update, result word
  sacl_dp #(
    .MAX_SETS    (MAX_SETS),
    .MAX_WAYS    (MAX_WAYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_word_o  (out_word_o)
  );

  // line state storage; read and write never hit the same cycle
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> hdl/sacl_checker.sv
// Port-level checks of the LFU cache, bound into the top level.
// Depends on sacl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sacl_checker import sacl_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_word_t              in_word_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_word_t             out_word_o
);

  // held result stays up
  `SACL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // busy right after taking a word
  `SACL_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // fresh result traces back to an accepted access and carries its kind
  `SACL_ASSERT_IMP(a_result_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2) && (out_word_o.was_write == $past(in_word_i.opcode, 2)))

  // a hit never evicts
  `SACL_ASSERT_IMP(a_hit_no_wb, clk_i, rst_ni, out_valid_o, !(out_word_o.hit && out_word_o.write_back))

endmodule

bind set_assoc_cache_lfu sacl_checker u_sacl_checker (.*);

>>> tb/sv/sacl_lfu_checker.sv
// Scoreboard for the set-associative LFU cache tag model: keeps its own copy
// of the lines and layout registers, predicts every result word and checks it.
// Depends on sacl_pkg.
module sacl_lfu_checker import sacl_pkg::*; #(
  parameter int unsigned MAX_SETS    = DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS    = DEF_MAX_WAYS,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_word_t             out_word_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o,
  output int unsigned           hits_o,
  output int unsigned           write_backs_o
);

  localparam int unsigned LINES        = MAX_SETS * MAX_WAYS;
  localparam int unsigned INDEX_LIMIT  = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned WAY_LIMIT    = $clog2(MAX_WAYS + 1) - 1;
  localparam logic [COUNT_WIDTH-1:0] USES_MAX = '1;
  localparam int unsigned REPORT_LIMIT = 10;

  logic                   line_valid_q [LINES];
  logic                   line_dirty_q [LINES];
  logic [31:0]            line_tag_q   [LINES];
  logic [COUNT_WIDTH-1:0] line_uses_q  [LINES];
  logic [3:0]             offset_q;
  logic [2:0]             index_q;
  logic [1:0]             ways_q;

  out_word_t   expected_words [$];
  out_word_t   want;
  int unsigned result_no;
  int unsigned reported;

  function automatic string show(out_word_t w);
    return $sformatf("hit=%b write_back=%b way_used=%0d was_write=%b",
                     w.hit, w.write_back, w.way_used, w.was_write);
  endfunction

  // One access against the shadow lines; returns the word the block owes.
  function automatic out_word_t access_lines(in_word_t w);
    int unsigned            ib, wb, ways, base, sel, shift, k;
    logic [31:0]            set_no, tag;
    logic                   found;
    logic [COUNT_WIDTH-1:0] least;
    out_word_t              r;
    ib     = (index_q > INDEX_LIMIT) ? INDEX_LIMIT : index_q;
    wb     = (ways_q > WAY_LIMIT) ? WAY_LIMIT : ways_q;
    ways   = 1 << wb;
    set_no = (w.address >> offset_q) & ((32'd1 << ib) - 32'd1);
    shift  = offset_q + ib;
    tag    = (shift >= 32) ? 32'd0 : (w.address >> shift);
    base   = set_no * MAX_WAYS;
    found  = 1'b0;
    sel    = 0;
    for (k = 0; k < ways; k++) begin
      if (!found && line_valid_q[base + k] && line_tag_q[base + k] == tag) begin
        found = 1'b1;
        sel   = k;
      end
    end
    r           = '0;
    r.hit       = found;
    r.was_write = (w.opcode == OP_WRITE);
    if (found) begin
      if (line_uses_q[base + sel] != USES_MAX) line_uses_q[base + sel]++;
      if (w.opcode == OP_WRITE) line_dirty_q[base + sel] = 1'b1;
    end else begin
      // LFU victim, lowest way on a tie
      least = line_uses_q[base];
      for (k = 1; k < ways; k++) begin
        if (line_uses_q[base + k] < least) begin
          least = line_uses_q[base + k];
          sel   = k;
        end
      end
      r.write_back             = line_valid_q[base + sel] && line_dirty_q[base + sel];
      line_valid_q[base + sel] = 1'b1;
      line_tag_q[base + sel]   = tag;
      line_uses_q[base + sel]  = COUNT_WIDTH'(1);
      line_dirty_q[base + sel] = (w.opcode == OP_WRITE);
    end
    r.way_used = sel[1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        line_valid_q[i] = 1'b0;
        line_dirty_q[i] = 1'b0;
        line_tag_q[i]   = '0;
        line_uses_q[i]  = '0;
      end
      offset_q = RST_OFFSET_BITS;
      index_q  = RST_INDEX_BITS;
      ways_q   = RST_WAY_BITS;
      expected_words.delete();
      result_no     = 0;
      reported      = 0;
      fail_count_o  = 0;
      hits_o        = 0;
      write_backs_o = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFFSET_BITS: offset_q = cfg_data_i[3:0];
          CFG_INDEX_BITS:  index_q  = cfg_data_i[2:0];
          CFG_WAY_BITS:    ways_q   = cfg_data_i[1:0];
          default: ;
        endcase
      end
      // retire before predicting, so a word can never match its own access
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("result %0d unexpected: %s", result_no, show(out_word_i));
          end
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.hit !== want.hit || out_word_i.write_back !== want.write_back ||
              out_word_i.way_used !== want.way_used ||
              out_word_i.was_write !== want.was_write) begin
            fail_count_o++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("result %0d mismatch: expected %s, got %s",
                       result_no, show(want), show(out_word_i));
            end
          end
        end
        result_no++;
      end
      if (in_valid_i && !in_stall_i) begin
        want = access_lines(in_word_i);
        if (want.hit) hits_o++;
        if (want.write_back) write_backs_o++;
        expected_words.push_back(want);
      end
      pending_o = expected_words.size();
    end
  end

endmodule

>>> tb/sv/set_assoc_cache_lfu_tb.sv
// Top of the testbench for set_assoc_cache_lfu: drives accesses, layout
// register writes and output stalls; the verdict comes from sacl_lfu_checker.
// Depends on sacl_pkg, sacl_lfu_checker and the block itself.
module set_assoc_cache_lfu_tb;
  import sacl_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned RANDOM_ITEMS  = 1950;
  localparam int unsigned MAX_GAP       = 13;
  // longest quiet stretch of a good run: clearing sweep or one word through
  // full gaps and stalls plus a register update; many times over
  localparam int unsigned STUCK_LIMIT   = 500;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned INDEX_LIMIT   = $clog2(DEF_MAX_SETS + 1) - 1;
  localparam int unsigned WAY_LIMIT     = $clog2(DEF_MAX_WAYS + 1) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_OFFSET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_word   = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  out_word_t             out_word;

  int unsigned pending, fail_count, hit_count, wb_count;
  int unsigned stuck_cycles = 0;
  int unsigned words_sent   = 0;
  int unsigned layouts      = 1;
  // set for stretches where neither side idles
  logic        no_idle      = 1'b0;
  // layout in effect, clamped as the block clamps it; used to build addresses
  int unsigned off_cur = RST_OFFSET_BITS;
  int unsigned ib_cur  = RST_INDEX_BITS;
  int unsigned wb_cur  = RST_WAY_BITS;

  always #(HALF_PERIOD) clk = ~clk;

  set_assoc_cache_lfu uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  sacl_lfu_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .hits_o        (hit_count),
    .write_backs_o (wb_count)
  );

  // Watchdog: any cycle with no word moving on either channel counts.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Result side: per word, raise stall for a randomly drawn hold, then take it.
  // The draw runs whether or not a word is waiting, so stalls land on every
  // phase of the block's access.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Issue one access word. Valid is only lowered when a gap is drawn, so a
  // back-to-back word keeps valid high with a new payload.
  task automatic send(opcode_e op, logic [31:0] addr);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{opcode: op, address: addr};
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back, then settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // New set/way layout; lines are kept and read under the new mapping.
  task automatic set_layout(int unsigned off, int unsigned ib, int unsigned wb);
    wait_idle();
    write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(off));
    write_reg(CFG_INDEX_BITS, CFG_DATA_W'(ib));
    write_reg(CFG_WAY_BITS, CFG_DATA_W'(wb));
    off_cur = off;
    ib_cur  = (ib > INDEX_LIMIT) ? INDEX_LIMIT : ib;
    wb_cur  = (wb > WAY_LIMIT) ? WAY_LIMIT : wb;
    layouts++;
  endtask

  // Address for a given tag and set under the current layout, random byte.
  function automatic logic [31:0] line_addr(int unsigned tag, int unsigned set_no);
    logic [31:0] a;
    a = $urandom;
    a = a & ((32'd1 << off_cur) - 32'd1);
    a = a | ((32'(set_no) & ((32'd1 << ib_cur) - 32'd1)) << off_cur);
    a = a | (32'(tag) << (off_cur + ib_cur));
    return a;
  endfunction

  initial begin : stimulus
    int unsigned n, tag_pool, set_pool, random_sent;
    random_sent = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed, reset layout: 32-byte blocks, 64 sets, 4 ways ---
    send(OP_READ, line_addr(0, 0));      // cold miss, way 0
    send(OP_WRITE, line_addr(0, 0));     // write hit, line goes dirty
    send(OP_WRITE, 32'hFFFF_FFFF);       // top address, last set
    send(OP_READ, line_addr(1, 0));      // fill ways 1..3 of set 0
    send(OP_READ, line_addr(2, 0));
    send(OP_READ, line_addr(3, 0));
    send(OP_READ, line_addr(4, 0));      // LFU tie among 1..3, lowest wins
    send(OP_WRITE, line_addr(1, 0));     // write miss fills dirty
    send(OP_READ, line_addr(5, 0));      // evicts that dirty line: write-back

    // oversized index and way registers clamp; largest block offset
    set_layout(15, 7, 3);
    send(OP_READ, 32'h0000_0000);
    send(OP_WRITE, 32'hFFFF_FFFF);
    send(OP_READ, 32'h7FFF_8000);

    // smallest layout: one set, one way, byte blocks
    set_layout(0, 0, 0);
    send(OP_READ, 32'h0000_0000);
    send(OP_WRITE, 32'h0000_0001);
    send(OP_READ, 32'h0000_0000);        // dirty victim
    send(OP_READ, 32'hFFFF_FFFF);

    // two ways, then back to one way to plant the same tag twice in the set
    set_layout(0, 0, 1);
    send(OP_READ, 32'h0000_0007);
    send(OP_READ, 32'h0000_0007);
    send(OP_READ, 32'h0000_0008);
    set_layout(0, 0, 0);
    send(OP_READ, 32'h0000_0008);
    set_layout(0, 0, 1);
    send(OP_WRITE, 32'h0000_0008);       // two matching ways: lowest one hits

    // --- random phases: a fresh layout each, most accesses drawn from a
    // few tags in a few sets so lines hit, age and get evicted ---
    while (random_sent < RANDOM_ITEMS) begin
      set_layout($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 3));
      no_idle  = ($urandom_range(0, 3) == 0);
      n        = $urandom_range(40, 160);
      tag_pool = $urandom_range(1, 2 << wb_cur);
      set_pool = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          send(opcode_e'($urandom_range(0, 1)), $urandom);
        end else begin
          send(opcode_e'($urandom_range(0, 1)),
               line_addr($urandom_range(0, tag_pool - 1), $urandom_range(0, set_pool - 1)));
        end
      end
      random_sent += n;
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d accesses over %0d cache layouts", words_sent, layouts);
    $display("%0d hits and %0d write-backs predicted, %0d mismatches",
             hit_count, wb_count, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/sacl_pkg.sv
hdl/sacl_ram.sv
hdl/sacl_ctrl.sv
hdl/sacl_dp.sv
hdl/set_assoc_cache_lfu.sv
hdl/sacl_checker.sv
tb/sv/sacl_lfu_checker.sv
tb/sv/set_assoc_cache_lfu_tb.sv
